[hw/rtl/mfq_pkg.sv]
// Shared types and constants for the multilevel feedback queue scheduler.
package mfq_pkg;

  typedef enum logic [2:0] {
    EV_ACCEPTED = 3'd0,
    EV_DROPPED  = 3'd1,
    EV_IDLE     = 3'd2,
    EV_RAN      = 3'd3,
    EV_FINISHED = 3'd4,
    EV_DEMOTED  = 3'd5
  } event_t;

  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic CFG_NUM_LEVELS   = 1'b0;
  localparam logic CFG_BASE_QUANTUM = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [15:0] job_id;
    logic [15:0] burst_len;
  } in_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [15:0] served_id;
    logic [2:0]  served_level;
    logic [31:0] wait_time;
    logic [31:0] service_time;
  } out_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] remaining;
    logic [31:0] arrived;
    logic [31:0] started;
    logic        has_started;
  } entry_t;

endpackage

[hw/rtl/mfq_store.sv]
// Job slot memory: one write port, one registered read port.
module mfq_store #(
  parameter int DEPTH = 320,
  parameter int AW    = 9
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  mfq_pkg::entry_t     wdata,
  input  logic [AW-1:0]       raddr,
  output mfq_pkg::entry_t     rdata
);

  mfq_pkg::entry_t mem [DEPTH];
  mfq_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/multilevel_feedback_queue_scheduler_core.sv]
// Top level of the multilevel feedback queue scheduler.
// An arrival beat's result is registered directly on acceptance; a tick beat first
// reads the head slot (ST_EXEC), then updates it and registers its result.
// Throughput: one arrival per cycle while out_stall is low; no new beat is taken
// during a tick's single read-modify-write pass through the job slot memory.
// Reset: synchronous, active low; clears queue pointers, time, slice and the
// output valid flag; the output data register and the slot memory hold no reset.
module multilevel_feedback_queue_scheduler_core #(
  parameter int QUEUE_DEPTH = 64,
  parameter int MAX_LEVELS  = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mfq_pkg::in_t      in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output mfq_pkg::out_t     out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [9:0]        cfg_data
);

  localparam int SLOTS = MAX_LEVELS * QUEUE_DEPTH;
  localparam int AW    = $clog2(SLOTS);
  localparam int LW    = $clog2(MAX_LEVELS);
  localparam int PW    = $clog2(QUEUE_DEPTH);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int SW    = 10 + MAX_LEVELS - 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  logic [2:0]    num_levels_r;
  logic [9:0]    base_quantum_r;

  logic [PW-1:0] head_r  [MAX_LEVELS];
  logic [PW-1:0] tail_r  [MAX_LEVELS];
  logic [CW-1:0] cnt_r   [MAX_LEVELS];
  logic [PW-1:0] head_nxt[MAX_LEVELS];
  logic [PW-1:0] tail_nxt[MAX_LEVELS];
  logic [CW-1:0] cnt_nxt [MAX_LEVELS];

  logic [31:0]   time_r, time_nxt;
  logic [SW-1:0] slice_r, slice_nxt;
  logic          owner_r, owner_nxt;

  logic [LW-1:0] lvl_r, lvl_nxt;
  logic          found_r, found_nxt;

  logic          out_valid_r, out_valid_nxt;
  mfq_pkg::out_t out_r, out_nxt;

  logic            in_acc;
  logic            found;
  logic [LW-1:0]   lsel;
  logic [AW-1:0]   raddr;
  logic            we;
  logic [AW-1:0]   waddr;
  mfq_pkg::entry_t wdata;
  mfq_pkg::entry_t rd;

  // Work values of the tick update
  logic [LW-1:0]   lnext;
  logic [LW-1:0]   dst;
  logic [2:0]      nl;
  logic [9:0]      q;
  logic [15:0]     rem;
  logic [31:0]     started;
  logic [SW-1:0]   sl;
  logic            move;

  function automatic logic [AW-1:0] slot(input logic [LW-1:0] l, input logic [PW-1:0] p);
    slot = AW'(l) * AW'(QUEUE_DEPTH) + AW'(p);
  endfunction

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    wrap_inc = (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + PW'(1);
  endfunction

  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Highest-priority non-empty level
  always_comb begin
    found = 1'b0;
    lsel  = '0;
    for (int k = MAX_LEVELS - 1; k >= 0; k--) begin
      if (cnt_r[k] != '0) begin
        found = 1'b1;
        lsel  = LW'(k);
      end
    end
  end

  assign raddr = slot(lsel, head_r[lsel]);

  mfq_store #(
    .DEPTH (SLOTS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd)
  );

  // Clamp the configuration into its working range
  always_comb begin
    if (num_levels_r < 3'd2) begin
      nl = 3'd2;
    end else if (32'(num_levels_r) > MAX_LEVELS) begin
      nl = 3'(MAX_LEVELS);
    end else begin
      nl = num_levels_r;
    end
    q = (base_quantum_r == '0) ? 10'd1 : base_quantum_r;
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    time_nxt      = time_r;
    slice_nxt     = slice_r;
    owner_nxt     = owner_r;
    lvl_nxt       = lvl_r;
    found_nxt     = found_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    we            = 1'b0;
    waddr         = slot(LW'(0), tail_r[0]);
    wdata         = '0;

    lnext   = (32'(lvl_r) == MAX_LEVELS - 1) ? lvl_r : lvl_r + LW'(1);
    rem     = (rd.remaining > 16'd1) ? rd.remaining - 16'd1 : 16'd0;
    started = rd.has_started ? rd.started : time_r;
    sl      = owner_r ? slice_r : (SW'(q) << lvl_r);
    if (sl != '0) begin
      sl = sl - SW'(1);
    end
    move = (32'(lvl_r) + 1 < 32'(nl)) && (sl == '0);
    dst  = (32'(cnt_r[lnext]) < QUEUE_DEPTH) ? lnext : lvl_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.opcode == mfq_pkg::OP_ARRIVE) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '0;
            out_nxt.served_id = in_data.job_id;
            if (32'(cnt_r[0]) >= QUEUE_DEPTH) begin
              out_nxt.event_res = mfq_pkg::EV_DROPPED;
            end else begin
              out_nxt.event_res = mfq_pkg::EV_ACCEPTED;
              if (cnt_r[0] == '0) begin
                owner_nxt = 1'b0;
              end
              we                = 1'b1;
              waddr             = slot(LW'(0), tail_r[0]);
              wdata.id          = in_data.job_id;
              wdata.remaining   = in_data.burst_len;
              wdata.arrived     = time_r;
              tail_nxt[0]       = wrap_inc(tail_r[0]);
              cnt_nxt[0]        = cnt_r[0] + CW'(1);
            end
          end else begin
            // Hold the chosen level while the head slot is read
            lvl_nxt   = lsel;
            found_nxt = found;
            state_nxt = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        out_nxt       = '0;
        time_nxt      = time_r + 32'd1;
        if (!found_r) begin
          out_nxt.event_res = mfq_pkg::EV_IDLE;
          owner_nxt         = 1'b0;
        end else begin
          out_nxt.served_id    = rd.id;
          out_nxt.served_level = 3'(lvl_r);
          wdata                = rd;
          wdata.remaining      = rem;
          wdata.started        = started;
          wdata.has_started    = 1'b1;
          we                   = 1'b1;
          waddr                = slot(lvl_r, head_r[lvl_r]);
          if (rem == '0) begin
            out_nxt.event_res    = mfq_pkg::EV_FINISHED;
            out_nxt.wait_time    = started - rd.arrived;
            out_nxt.service_time = time_r + 32'd1 - started;
            head_nxt[lvl_r]      = wrap_inc(head_r[lvl_r]);
            cnt_nxt[lvl_r]       = cnt_r[lvl_r] - CW'(1);
            owner_nxt            = 1'b0;
          end else begin
            out_nxt.event_res = mfq_pkg::EV_RAN;
            slice_nxt         = sl;
            owner_nxt         = 1'b1;
            if (move) begin
              // Pop the head and append the job to the destination tail
              owner_nxt       = 1'b0;
              waddr           = slot(dst, tail_r[dst]);
              head_nxt[lvl_r] = wrap_inc(head_r[lvl_r]);
              tail_nxt[dst]   = wrap_inc(tail_r[dst]);
              if (dst != lvl_r) begin
                out_nxt.event_res = mfq_pkg::EV_DEMOTED;
                cnt_nxt[lvl_r]    = cnt_r[lvl_r] - CW'(1);
                cnt_nxt[dst]      = cnt_r[dst] + CW'(1);
              end
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      num_levels_r   <= 3'd3;
      base_quantum_r <= 10'd4;
      time_r         <= '0;
      slice_r        <= '0;
      owner_r        <= 1'b0;
      out_valid_r    <= 1'b0;
      found_r        <= 1'b0;
      lvl_r          <= '0;
      for (int k = 0; k < MAX_LEVELS; k++) begin
        head_r[k] <= '0;
        tail_r[k] <= '0;
        cnt_r[k]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      time_r      <= time_nxt;
      slice_r     <= slice_nxt;
      owner_r     <= owner_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
      lvl_r       <= lvl_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_we) begin
        if (cfg_index == mfq_pkg::CFG_NUM_LEVELS) begin
          num_levels_r <= cfg_data[2:0];
        end else begin
          base_quantum_r <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EXEC |=> state_r == ST_IDLE)
    else $error("update pass lasted more than one cycle");

  a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EXEC |=> out_valid_r)
    else $error("tick finished without a result");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> (state_r == ST_IDLE))
    else $error("beat accepted during update pass");

  a_level0_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r[0]) <= QUEUE_DEPTH)
    else $error("level 0 count overflow");

endmodule
